// ===== design/plt_pkg.sv =====
// Shared types and constants for the polynomial term lexer.
// Used by plt_lex_core and polynomial_term_lexer_top; depends on nothing else.
package plt_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic signed [16:0] coefficient;
    logic [7:0]         exponent;
    logic               is_constant;
    logic [1:0]         error_code;
    logic               end_of_expression;
  } out_t;

  typedef enum logic [2:0] {
    PH_START,
    PH_SIGN,
    PH_COEF,
    PH_X,
    PH_CARET,
    PH_EXP
  } phase_t;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_CARET = 2'd1;
  localparam logic [1:0] ERR_CHAR  = 2'd2;
  localparam logic [1:0] ERR_EMPTY = 2'd3;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

endpackage

// ===== design/plt_lex_core.sv =====
// Term state machine of the polynomial term lexer: one character per beat.
// Depends on plt_pkg; instantiated by polynomial_term_lexer_top.
module plt_lex_core #(
  parameter int COEF_BITS = 16,
  parameter int EXP_BITS  = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  plt_pkg::in_t  item,
  output logic          emit,
  output plt_pkg::out_t res
);
  import plt_pkg::*;

  localparam int MW = (COEF_BITS > 17) ? COEF_BITS : 17;
  localparam int EW = (EXP_BITS > 8) ? EXP_BITS : 8;

  phase_t               phase, phase_next;
  logic                 negative_term, negative_term_next;
  logic [COEF_BITS-1:0] coef_accum, coef_accum_next;
  logic                 coef_present, coef_present_next;
  logic [EXP_BITS-1:0]  exp_accum, exp_accum_next;
  logic                 discarding, discarding_next;

  logic [7:0] ch;
  logic       last;
  logic [3:0] digit;
  logic       is_num, is_sign, is_skip, go_on;

  function automatic logic [COEF_BITS-1:0] coef_digit(
    input logic [COEF_BITS-1:0] acc, input logic [3:0] d);
    logic [COEF_BITS+3:0] v;
    v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + (COEF_BITS+4)'(d);
    if (|v[COEF_BITS+3:COEF_BITS]) return '1;
    return v[COEF_BITS-1:0];
  endfunction

  function automatic logic [EXP_BITS-1:0] exp_digit(
    input logic [EXP_BITS-1:0] acc, input logic [3:0] d);
    logic [EXP_BITS+3:0] v;
    v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + (EXP_BITS+4)'(d);
    if (|v[EXP_BITS+3:EXP_BITS]) return '1;
    return v[EXP_BITS-1:0];
  endfunction

  function automatic out_t fail_beat(input logic [1:0] code, input logic fin);
    out_t r;
    r = '0;
    r.error_code        = code;
    r.end_of_expression = fin;
    return r;
  endfunction

  // Close the term described by the given state.
  function automatic out_t finish_beat(
    input phase_t ph, input logic neg, input logic [COEF_BITS-1:0] c,
    input logic cp, input logic [EXP_BITS-1:0] e, input logic fin);
    out_t           r;
    logic [MW-1:0]  mag;
    logic [16:0]    m17;
    logic [EW-1:0]  ex;
    r = '0;
    if (ph == PH_START || ph == PH_SIGN) return fail_beat(ERR_EMPTY, fin);
    if (ph == PH_CARET) return fail_beat(ERR_CARET, fin);
    mag = cp ? MW'(c) : MW'(1);
    m17 = mag[16:0];
    ex  = EW'(e);
    r.coefficient       = neg ? signed'(~m17 + 17'd1) : signed'(m17);
    r.is_constant       = (ph == PH_COEF);
    r.exponent          = (ph == PH_COEF) ? 8'd0 :
                          (ph == PH_EXP) ? ex[7:0] : 8'd1;
    r.error_code        = ERR_NONE;
    r.end_of_expression = fin;
    return r;
  endfunction

  assign ch       = item.char_code;
  assign last     = item.last_char;
  assign is_num   = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
  assign is_skip  = (ch == CH_SPACE) || (ch == CH_CR) || (ch == CH_LF);
  assign digit    = 4'(ch - CH_ZERO);

  always_comb begin
    phase_next         = phase;
    negative_term_next = negative_term;
    coef_accum_next    = coef_accum;
    coef_present_next  = coef_present;
    exp_accum_next     = exp_accum;
    discarding_next    = discarding;
    emit               = 1'b0;
    res                = '0;
    go_on              = 1'b1;

    if (discarding) begin
      go_on = 1'b0;
      if (last) begin
        phase_next         = PH_START;
        negative_term_next = 1'b0;
        coef_accum_next    = '0;
        coef_present_next  = 1'b0;
        exp_accum_next     = '0;
        discarding_next    = 1'b0;
      end
    end else if (is_skip) begin
      go_on = 1'b1;
    end else if (is_sign) begin
      go_on = 1'b0;
      if (last) begin
        emit = 1'b1;
        res  = fail_beat((phase == PH_CARET) ? ERR_CARET : ERR_EMPTY, 1'b1);
      end else if (phase == PH_START) begin
        negative_term_next = (ch == CH_MINUS);
        phase_next         = PH_SIGN;
      end else if (phase == PH_SIGN) begin
        emit = 1'b1;
        res  = fail_beat(ERR_EMPTY, 1'b0);
      end else if (phase == PH_CARET) begin
        emit = 1'b1;
        res  = fail_beat(ERR_CARET, 1'b0);
      end else begin
        // Close this term; the sign opens the next one.
        emit = 1'b1;
        res  = finish_beat(phase, negative_term, coef_accum, coef_present,
                           exp_accum, 1'b0);
      end
      if (emit || !last) begin
        coef_accum_next   = '0;
        coef_present_next = 1'b0;
        exp_accum_next    = '0;
      end
      if (emit) begin
        phase_next         = PH_START;
        negative_term_next = 1'b0;
        discarding_next    = !last && (res.error_code != ERR_NONE);
      end
      if (emit && !last && res.error_code == ERR_NONE) begin
        negative_term_next = (ch == CH_MINUS);
        phase_next         = PH_SIGN;
      end
    end else if (is_num) begin
      if (phase == PH_START || phase == PH_SIGN || phase == PH_COEF) begin
        coef_accum_next   = coef_digit(coef_accum, digit);
        coef_present_next = 1'b1;
        phase_next        = PH_COEF;
      end else if (phase == PH_CARET || phase == PH_EXP) begin
        exp_accum_next = exp_digit(exp_accum, digit);
        phase_next     = PH_EXP;
      end else begin
        go_on = 1'b0;
        emit  = 1'b1;
        res   = fail_beat(ERR_CHAR, last);
      end
    end else if (ch == CH_X) begin
      if (phase == PH_START || phase == PH_SIGN || phase == PH_COEF) begin
        phase_next = PH_X;
      end else begin
        go_on = 1'b0;
        emit  = 1'b1;
        res   = fail_beat(ERR_CHAR, last);
      end
    end else if (ch == CH_CARET) begin
      if (phase == PH_X) begin
        phase_next = PH_CARET;
      end else begin
        go_on = 1'b0;
        emit  = 1'b1;
        res   = fail_beat(ERR_CHAR, last);
      end
    end else begin
      go_on = 1'b0;
      emit  = 1'b1;
      res   = fail_beat(ERR_CHAR, last);
    end

    // Error outside the sign path: drop the term, discard up to the last char.
    if (!discarding && !is_sign && emit) begin
      phase_next         = PH_START;
      negative_term_next = 1'b0;
      coef_accum_next    = '0;
      coef_present_next  = 1'b0;
      exp_accum_next     = '0;
      discarding_next    = !last;
    end

    if (go_on && last) begin
      emit               = 1'b1;
      res                = finish_beat(phase_next, negative_term_next,
                                       coef_accum_next, coef_present_next,
                                       exp_accum_next, 1'b1);
      phase_next         = PH_START;
      negative_term_next = 1'b0;
      coef_accum_next    = '0;
      coef_present_next  = 1'b0;
      exp_accum_next     = '0;
      discarding_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_START;
      negative_term <= 1'b0;
      coef_accum    <= '0;
      coef_present  <= 1'b0;
      exp_accum     <= '0;
      discarding    <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      negative_term <= negative_term_next;
      coef_accum    <= coef_accum_next;
      coef_present  <= coef_present_next;
      exp_accum     <= exp_accum_next;
      discarding    <= discarding_next;
    end
  end

  a_no_beat_while_discarding: assert property (@(posedge clk) disable iff (rst)
    discarding |-> !emit)
    else $error("beat produced while discarding");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    accept && last |=> phase == PH_START && !discarding && !coef_present)
    else $error("state not cleared after last character");

  a_error_empty_payload: assert property (@(posedge clk) disable iff (rst)
    emit && res.error_code != ERR_NONE |-> res.coefficient == 17'sd0 &&
      res.exponent == 8'd0 && !res.is_constant)
    else $error("error beat carries term fields");

  a_error_discard: assert property (@(posedge clk) disable iff (rst)
    accept && emit && !last && res.error_code != ERR_NONE |=> discarding)
    else $error("error before last character did not start discarding");

endmodule

// ===== design/polynomial_term_lexer_top.sv =====
// Polynomial term lexer: splits polynomial text into signed terms.
// Usage: feed one character per beat on in_data (char_code, last_char) with
// in_valid; the receiver holds in_stall low to take a beat.
// Each finished term or error comes out as one beat on out_data with
// out_valid; the downstream side raises out_stall to hold it.
// A term goes to out_data, or to the skid register behind a stalled output,
// when the character that ends it (the next sign or the last char) is taken.
// Throughput: one character per cycle while in_stall is low; the core
// updates its term state in a single pass per character, and the result
// and skid registers decouple the sides so characters flow while a term waits.
// in_stall goes high only while the skid register holds a beat, that is,
// when two terms are waiting behind a stalled output.
// Reset: clears the term state, the discard flag and both output valid flags.
// Depends on plt_pkg and plt_lex_core.
module polynomial_term_lexer_top #(
  parameter int COEF_BITS = 16,
  parameter int EXP_BITS  = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  plt_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output plt_pkg::out_t out_data
);
  import plt_pkg::*;

  logic accept;
  logic emit;
  out_t res;
  logic skid_valid;
  out_t skid_data;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;

  plt_lex_core #(
    .COEF_BITS(COEF_BITS),
    .EXP_BITS (EXP_BITS)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .accept(accept),
    .item  (in_data),
    .emit  (emit),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // Input is held; drain the skid beat first.
      if (!out_stall) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (accept && emit) begin
      if (!out_valid || !out_stall) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (!out_stall) out_data <= skid_data;
    end else if (accept && emit) begin
      if (!out_valid || !out_stall) out_data <= res;
      else skid_data <= res;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid beat held with output empty");

  a_skid_fills: assert property (@(posedge clk) disable iff (rst)
    accept && emit && out_valid && out_stall |=> skid_valid)
    else $error("beat lost behind stalled output");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !accept)
    else $error("character taken while skid register full");

endmodule
